>>> hdl/nps_pkg.sv
// Shared types and constants of the normal-profile point sampler.
package nps_pkg;

    localparam int HALF_LEN_MAX   = 31;
    localparam int PYRAMID_LEVELS = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] LVL_MAX =
        2'((PYRAMID_LEVELS - 1 > 3) ? 3 : PYRAMID_LEVELS - 1);

    localparam logic signed [15:0] UNIT_ONE  = 16'sd16384;
    localparam logic [11:0]        STEP_LOW  = 12'd64;
    localparam logic [11:0]        STEP_HIGH = 12'd2048;
    localparam logic [11:0]        OFF_STEP  = 12'd256;   // 1.0 in Q4.8

    // register map
    localparam logic [1:0] REG_HALF_LENGTH  = 2'd0;
    localparam logic [1:0] REG_STEP_Q8      = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [4:0]  RST_HALF_LENGTH  = 5'd4;
    localparam logic [11:0] RST_STEP_Q8      = 12'd256;
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;

    localparam int ACC_W  = 40;   // j * u * step
    localparam int COEF_W = 28;   // u * step
    localparam int PT_W   = 18;   // rounded point
    localparam int FRAC_W = 22;   // Q2.14 times Q4.8

    typedef struct packed {
        logic signed [16:0] vx;
        logic signed [16:0] vy;
    } unit_req_t;

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic               ok;
    } unit_rsp_t;

    // one classified landmark, handed from front to back
    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic [11:0]        cl_x;
        logic [11:0]        cl_y;
        logic [11:0]        lim_x;
        logic [11:0]        lim_y;
        logic [11:0]        step;
        logic [4:0]         k;
        logic signed [5:0]  off;
    } desc_t;

endpackage

>>> hdl/nps_unit.sv
// Iterative vector normalizer: square sum, bit-serial square root, two divides.
module nps_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_i,
    input  nps_pkg::unit_req_t  req_i,
    output logic                done_o,
    output nps_pkg::unit_rsp_t  rsp_o
);
    import nps_pkg::*;

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_SQX  = 3'd1;
    localparam logic [2:0] U_SQY  = 3'd2;
    localparam logic [2:0] U_SQRT = 3'd3;
    localparam logic [2:0] U_DSET = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;
    localparam logic [2:0] U_DONE = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        neg_x_reg, neg_y_reg, ok_reg, sel_y_reg;
    logic [15:0] ax_reg, ay_reg;
    logic [31:0] n2_reg, rad_reg, root_reg, drem_reg;
    logic [33:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] nlo_reg, q_reg, qx_reg;

    logic [31:0] n2_sum;
    logic [34:0] rem_t, trial;
    logic        sq_ge;
    logic [46:0] num;
    logic [32:0] div_t;
    logic        dv_ge;
    logic [15:0] q_next;

    assign n2_sum = n2_reg + ay_reg * ay_reg;

    assign rem_t = {rem_reg[32:0], rad_reg[31:30]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = rem_t >= trial;

    assign num   = {(sel_y_reg ? ay_reg : ax_reg), 30'b0} + 47'(root_reg[31:1]);
    assign div_t = {drem_reg, nlo_reg[15]};
    assign dv_ge = div_t >= {1'b0, root_reg};
    assign q_next = {q_reg[14:0], dv_ge};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: if (start_i) state_next = U_SQX;
            U_SQX:  state_next = U_SQY;
            U_SQY:  state_next = (n2_sum == '0) ? U_DONE : U_SQRT;
            U_SQRT: if (cnt_reg == 5'd31) state_next = U_DSET;
            U_DSET: state_next = U_DIV;
            U_DIV:  if (cnt_reg == 5'd15) state_next = sel_y_reg ? U_DONE : U_DSET;
            // a new run may start in the cycle the previous result is taken
            U_DONE: state_next = start_i ? U_SQX : U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE, U_DONE: begin
                if (start_i) begin
                    neg_x_reg <= req_i.vx < 0;
                    neg_y_reg <= req_i.vy < 0;
                    ax_reg    <= 16'((req_i.vx < 0) ? -req_i.vx : req_i.vx);
                    ay_reg    <= 16'((req_i.vy < 0) ? -req_i.vy : req_i.vy);
                end
            end
            U_SQX: n2_reg <= ax_reg * ax_reg;
            U_SQY: begin
                n2_reg    <= n2_sum;
                rad_reg   <= n2_sum;
                ok_reg    <= n2_sum != '0;
                rem_reg   <= '0;
                root_reg  <= '0;
                cnt_reg   <= '0;
                sel_y_reg <= 1'b0;
            end
            U_SQRT: begin
                rem_reg  <= sq_ge ? 34'(rem_t - trial) : rem_t[33:0];
                root_reg <= {root_reg[30:0], sq_ge};
                rad_reg  <= {rad_reg[29:0], 2'b00};
                cnt_reg  <= cnt_reg + 5'd1;
            end
            U_DSET: begin
                // quotient stays below 2^16, so the top part is already reduced
                drem_reg <= 32'(num[46:16]);
                nlo_reg  <= num[15:0];
                cnt_reg  <= '0;
            end
            U_DIV: begin
                drem_reg <= dv_ge ? 32'(div_t - {1'b0, root_reg}) : div_t[31:0];
                nlo_reg  <= {nlo_reg[14:0], 1'b0};
                q_reg    <= q_next;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd15 && !sel_y_reg) begin
                    qx_reg    <= q_next;
                    sel_y_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign done_o   = state_reg == U_DONE;
    assign rsp_o.ok = ok_reg;
    assign rsp_o.ux = !ok_reg ? '0 : (neg_x_reg ? -$signed(qx_reg) : $signed(qx_reg));
    assign rsp_o.uy = !ok_reg ? '0 : (neg_y_reg ? -$signed(q_reg) : $signed(q_reg));

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> (state_reg == U_IDLE || state_reg == U_DONE))
        else $error("normalizer started while busy");

endmodule

>>> hdl/nps_front.sv
// Front end: accepts landmarks, forms neighbor unit vectors and the normal.
module nps_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [11:0]         s_center_x,
    input  logic [11:0]         s_center_y,
    input  logic [11:0]         s_prev_x,
    input  logic [11:0]         s_prev_y,
    input  logic [11:0]         s_next_x,
    input  logic [11:0]         s_next_y,
    input  logic [1:0]          s_pyramid_level,
    input  logic signed [5:0]   s_center_offset,
    input  logic [4:0]          half_length_i,
    input  logic [11:0]         step_q8_i,
    input  logic [11:0]         image_width_i,
    input  logic [11:0]         image_height_i,
    input  logic                full_i,
    output logic                push_o,
    output nps_pkg::desc_t      desc_o
);
    import nps_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_A    = 3'd1;
    localparam logic [2:0] F_B    = 3'd2;
    localparam logic [2:0] F_N    = 3'd3;
    localparam logic [2:0] F_D    = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [11:0]        cx_reg, cy_reg;
    logic [1:0]         lvl_reg;
    logic signed [5:0]  off_reg;
    logic signed [16:0] vbx_reg, vby_reg;
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg, ux_reg, uy_reg;
    logic               a_ok_reg;

    logic               accept, unit_start, unit_done, vanish;
    unit_req_t          unit_req;
    unit_rsp_t          unit_rsp;
    logic signed [16:0] vax, vay, dx, dy;
    logic [1:0]         lvl_s;
    logic [11:0]        lim_x_raw, lim_y_raw;

    assign s_ready = state_reg == F_IDLE;
    assign accept  = s_valid && s_ready;

    assign vax = $signed({5'b0, s_prev_x}) - $signed({5'b0, s_center_x});
    assign vay = $signed({5'b0, s_prev_y}) - $signed({5'b0, s_center_y});
    assign dx  = $signed({by_reg[15], by_reg}) - $signed({ay_reg[15], ay_reg});
    assign dy  = $signed({ax_reg[15], ax_reg}) - $signed({bx_reg[15], bx_reg});
    assign vanish = dx >= -17'sd2 && dx <= 17'sd2 && dy >= -17'sd2 && dy <= 17'sd2;

    always_comb begin
        case (state_reg)
            F_IDLE:  begin unit_req.vx = vax;     unit_req.vy = vay;     end
            F_A:     begin unit_req.vx = vbx_reg; unit_req.vy = vby_reg; end
            default: begin unit_req.vx = dx;      unit_req.vy = dy;      end
        endcase
    end

    assign unit_start = accept || (state_reg == F_A && unit_done)
                        || (state_reg == F_N && !vanish);

    nps_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (unit_start),
        .req_i   (unit_req),
        .done_o  (unit_done),
        .rsp_o   (unit_rsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_A;
            F_A:    if (unit_done) state_next = F_B;
            F_B:    if (unit_done) state_next = F_N;
            F_N:    state_next = vanish ? F_PUSH : F_D;
            F_D:    if (unit_done) state_next = F_PUSH;
            F_PUSH: if (!full_i) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    cx_reg  <= s_center_x;
                    cy_reg  <= s_center_y;
                    lvl_reg <= s_pyramid_level;
                    off_reg <= s_center_offset;
                    vbx_reg <= $signed({5'b0, s_next_x}) - $signed({5'b0, s_center_x});
                    vby_reg <= $signed({5'b0, s_next_y}) - $signed({5'b0, s_center_y});
                end
            end
            F_A: begin
                if (unit_done) begin
                    ax_reg   <= unit_rsp.ux;
                    ay_reg   <= unit_rsp.uy;
                    a_ok_reg <= unit_rsp.ok;
                end
            end
            F_B: begin
                if (unit_done) begin
                    bx_reg <= unit_rsp.ux;
                    by_reg <= unit_rsp.uy;
                end
            end
            F_N: begin
                // near-zero normal: fall back to -a, or +x when a is zero
                if (vanish) begin
                    ux_reg <= a_ok_reg ? -ax_reg : UNIT_ONE;
                    uy_reg <= a_ok_reg ? -ay_reg : '0;
                end
            end
            F_D: begin
                if (unit_done) begin
                    ux_reg <= unit_rsp.ux;
                    uy_reg <= unit_rsp.uy;
                end
            end
            default: ;
        endcase
    end

    assign lvl_s     = (lvl_reg > LVL_MAX) ? LVL_MAX : lvl_reg;
    assign lim_x_raw = image_width_i >> lvl_s;
    assign lim_y_raw = image_height_i >> lvl_s;

    assign push_o       = state_reg == F_PUSH && !full_i;
    assign desc_o.ux    = ux_reg;
    assign desc_o.uy    = uy_reg;
    assign desc_o.cl_x  = cx_reg >> lvl_s;
    assign desc_o.cl_y  = cy_reg >> lvl_s;
    assign desc_o.lim_x = (lim_x_raw == '0) ? 12'd1 : lim_x_raw;
    assign desc_o.lim_y = (lim_y_raw == '0) ? 12'd1 : lim_y_raw;
    assign desc_o.step  = (step_q8_i < STEP_LOW) ? STEP_LOW :
                          (step_q8_i > STEP_HIGH) ? STEP_HIGH : step_q8_i;
    assign desc_o.k     = half_length_i;
    assign desc_o.off   = off_reg;

endmodule

>>> hdl/nps_fifo.sv
// Short descriptor queue between front and back.
module nps_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_i,
    input  nps_pkg::desc_t  wr_data_i,
    input  logic            pop_i,
    output nps_pkg::desc_t  rd_data_o,
    output logic            full_o,
    output logic            empty_o
);
    import nps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full_o  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty_o = count_reg == '0;
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;
    assign rd_data_o = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/nps_back.sv
// Back end: offset walk, walk out to +k, then emit points down to -k.
module nps_back #(
    parameter int MAX_HALF_LENGTH = nps_pkg::HALF_LEN_MAX
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            empty_i,
    output logic            pop_o,
    input  nps_pkg::desc_t  desc_i,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [11:0]     m_sample_x,
    output logic [11:0]     m_sample_y,
    output logic            m_last_sample
);
    import nps_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_HALF_LENGTH + 2);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_OFF   = 3'd1;
    localparam logic [2:0] B_MULX  = 3'd2;
    localparam logic [2:0] B_MULY  = 3'd3;
    localparam logic [2:0] B_FWD   = 3'd4;
    localparam logic [2:0] B_EMIT  = 3'd5;
    localparam logic [2:0] B_DWALK = 3'd6;

    logic [2:0]               state_reg, state_next;
    desc_t                    desc_reg;
    logic signed [COEF_W-1:0] cx_reg, cy_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic signed [PT_W-1:0]   px_reg, py_reg, offx_reg, offy_reg;
    logic [4:0]               wcnt_reg;
    logic [CNT_W-1:0]         emit_cnt_reg;
    logic                     m_valid_reg, m_last_reg;
    logic [11:0]              m_x_reg, m_y_reg;

    logic signed [ACC_W-1:0]  accx_next, accy_next;
    logic signed [PT_W-1:0]   ptx, pty;
    logic                     differ, load, sub;
    logic [5:0]               off_mag;
    logic [4:0]               k_sat;
    logic signed [COEF_W-1:0] prod;

    // round half to even of acc / 2^22 (floor plus tie correction)
    function automatic logic signed [PT_W-1:0] round_pt(input logic signed [ACC_W-1:0] a);
        logic signed [PT_W-1:0] q;
        logic [FRAC_W-1:0]      r;
        q = a[ACC_W-1:FRAC_W];
        r = a[FRAC_W-1:0];
        return q + PT_W'(r[FRAC_W-1] && ((|r[FRAC_W-2:0]) || q[0]));
    endfunction

    function automatic logic [11:0] clamp_axis(input logic [11:0] base,
                                               input logic signed [PT_W-1:0] p,
                                               input logic signed [PT_W-1:0] o,
                                               input logic [11:0] lim);
        logic signed [PT_W+1:0] v;
        v = $signed({{(PT_W-10){1'b0}}, base}) + (PT_W+2)'(p) + (PT_W+2)'(o);
        if (v < 0) return '0;
        if (v >= $signed({{(PT_W-10){1'b0}}, lim})) return lim - 12'd1;
        return v[11:0];
    endfunction

    assign sub       = state_reg == B_DWALK || (state_reg == B_FWD && wcnt_reg == '0);
    assign accx_next = sub ? accx_reg - ACC_W'(cx_reg) : accx_reg + ACC_W'(cx_reg);
    assign accy_next = sub ? accy_reg - ACC_W'(cy_reg) : accy_reg + ACC_W'(cy_reg);
    assign ptx       = round_pt(accx_reg);
    assign pty       = round_pt(accy_reg);
    assign differ    = ptx != px_reg || pty != py_reg;

    assign off_mag = desc_i.off[5] ? 6'(-desc_i.off) : 6'(desc_i.off);
    assign k_sat   = (desc_reg.k > 5'(MAX_HALF_LENGTH)) ? 5'(MAX_HALF_LENGTH) : desc_reg.k;
    assign prod    = COEF_W'((state_reg == B_MULX ? desc_reg.ux : desc_reg.uy)
                             * $signed({1'b0, desc_reg.step}));

    assign pop_o = state_reg == B_IDLE && !empty_i;
    assign load  = state_reg == B_EMIT && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!empty_i) state_next = B_OFF;
            B_OFF:   if (wcnt_reg == '0) state_next = B_MULX;
            B_MULX:  state_next = B_MULY;
            B_MULY:  state_next = B_FWD;
            B_FWD:   if (wcnt_reg == '0) state_next = B_EMIT;
            B_EMIT:  if (load) state_next = (emit_cnt_reg == CNT_W'(1)) ? B_IDLE : B_DWALK;
            B_DWALK: if (differ) state_next = B_EMIT;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (!empty_i) begin
                    // offset walk runs on the unscaled normal: step of 1.0
                    desc_reg <= desc_i;
                    cx_reg   <= COEF_W'(desc_i.ux * $signed({1'b0, OFF_STEP}));
                    cy_reg   <= COEF_W'(desc_i.uy * $signed({1'b0, OFF_STEP}));
                    accx_reg <= ACC_W'(desc_i.ux * $signed({1'b0, OFF_STEP}));
                    accy_reg <= ACC_W'(desc_i.uy * $signed({1'b0, OFF_STEP}));
                    px_reg   <= '0;
                    py_reg   <= '0;
                    wcnt_reg <= (off_mag == '0) ? '0 : 5'(off_mag - 6'd1);
                end
            end
            B_OFF: begin
                if (wcnt_reg == '0) begin
                    offx_reg <= (desc_reg.off > 0) ? px_reg : -px_reg;
                    offy_reg <= (desc_reg.off > 0) ? py_reg : -py_reg;
                end else begin
                    accx_reg <= accx_next;
                    accy_reg <= accy_next;
                    if (differ) begin
                        px_reg   <= ptx;
                        py_reg   <= pty;
                        wcnt_reg <= wcnt_reg - 5'd1;
                    end
                end
            end
            B_MULX: begin
                cx_reg   <= prod;
                accx_reg <= ACC_W'(prod);
            end
            B_MULY: begin
                cy_reg       <= prod;
                accy_reg     <= ACC_W'(prod);
                px_reg       <= '0;
                py_reg       <= '0;
                wcnt_reg     <= k_sat;
                emit_cnt_reg <= CNT_W'({k_sat, 1'b1});
            end
            B_FWD, B_DWALK: begin
                // at the end of the outward walk this steps j back by one
                accx_reg <= accx_next;
                accy_reg <= accy_next;
                if (wcnt_reg != '0 || state_reg == B_DWALK) begin
                    if (differ) begin
                        px_reg <= ptx;
                        py_reg <= pty;
                        if (state_reg == B_FWD) wcnt_reg <= wcnt_reg - 5'd1;
                    end
                end
            end
            B_EMIT: begin
                if (load) begin
                    m_x_reg      <= clamp_axis(desc_reg.cl_x, px_reg, offx_reg, desc_reg.lim_x);
                    m_y_reg      <= clamp_axis(desc_reg.cl_y, py_reg, offy_reg, desc_reg.lim_y);
                    m_last_reg   <= emit_cnt_reg == CNT_W'(1);
                    emit_cnt_reg <= emit_cnt_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_x    = m_x_reg;
    assign m_sample_y    = m_y_reg;
    assign m_last_sample = m_last_reg;

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_EMIT |-> emit_cnt_reg != '0)
        else $error("emit with no points left");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && emit_cnt_reg == CNT_W'(1)) |=> state_reg == B_IDLE && m_last_reg)
        else $error("profile did not close after last point");

endmodule

>>> hdl/normal_profile_point_sampler_core.sv
// Normal-profile point sampler top level: config registers, front, queue, back.
//
// For each landmark request (center plus its two neighbors) the core emits
// 2k+1 pixel positions along the landmark normal, from +k down to -k, with
// last_sample set on the final one; positions are at the requested pyramid
// level and clamped to that level's image. The front takes one landmark at
// a time and runs a shared normalizer three times (both neighbor directions,
// then the normal; the third run is skipped when the normal vanishes). A
// normalizer run is a square sum, a 32-step square root and two 16-step
// divides; a zero vector skips the root and the divides. The back walks
// one step count j per cycle: an offset walk and setup, then the walk out
// to +k and back to -k (one to about six j per point, more for small
// steps), with each point emitted on the way back, held while the output
// stalls. A two-entry descriptor queue lets front and back run on different
// landmarks, so the sustained rate is the slower of the two, typically the
// normalizer. Config registers must only change while idle.
module normal_profile_point_sampler_core #(
    parameter int MAX_HALF_LENGTH = nps_pkg::HALF_LEN_MAX
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [11:0]        cfg_wdata,
    // landmark requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_center_x,
    input  logic [11:0]        s_center_y,
    input  logic [11:0]        s_prev_x,
    input  logic [11:0]        s_prev_y,
    input  logic [11:0]        s_next_x,
    input  logic [11:0]        s_next_y,
    input  logic [1:0]         s_pyramid_level,
    input  logic signed [5:0]  s_center_offset,
    // sample points
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_sample_x,
    output logic [11:0]        m_sample_y,
    output logic               m_last_sample
);
    import nps_pkg::*;

    logic [4:0]  half_length_reg;
    logic [11:0] step_q8_reg, image_width_reg, image_height_reg;

    logic        q_push, q_pop, q_full, q_empty;
    desc_t       q_wr_data, q_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_length_reg  <= RST_HALF_LENGTH;
            step_q8_reg      <= RST_STEP_Q8;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HALF_LENGTH:  half_length_reg  <= cfg_wdata[4:0];
                REG_STEP_Q8:      step_q8_reg      <= cfg_wdata;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: classify the landmark, produce normal and level bounds
    nps_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .s_prev_x        (s_prev_x),
        .s_prev_y        (s_prev_y),
        .s_next_x        (s_next_x),
        .s_next_y        (s_next_y),
        .s_pyramid_level (s_pyramid_level),
        .s_center_offset (s_center_offset),
        .half_length_i   (half_length_reg),
        .step_q8_i       (step_q8_reg),
        .image_width_i   (image_width_reg),
        .image_height_i  (image_height_reg),
        .full_i          (q_full),
        .push_o          (q_push),
        .desc_o          (q_wr_data)
    );

    nps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (q_push),
        .wr_data_i (q_wr_data),
        .pop_i     (q_pop),
        .rd_data_o (q_rd_data),
        .full_o    (q_full),
        .empty_o   (q_empty)
    );

    // back: rounding walks and point output, with its own output register
    nps_back #(
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .empty_i       (q_empty),
        .pop_o         (q_pop),
        .desc_i        (q_rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_x    (m_sample_x),
        .m_sample_y    (m_sample_y),
        .m_last_sample (m_last_sample)
    );

endmodule
